// File: rtl/core/vdi_pkg.sv
// ----------------------------------------------------------------------------
// vdi_pkg
// Shared constants, command and status types and float compare helpers for
// the vertex de-duplication indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package vdi_pkg;

  localparam int unsigned VdiTableDepth = 256;
  localparam int unsigned CoordW        = 32;
  localparam int unsigned IdxW          = 8;
  localparam int unsigned VertexW       = 3 * CoordW;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch the incoming vertex, rewind the search
    logic scan;        // advance the search by one table entry
    logic load_match;  // result: matching position
    logic load_full;   // result: table full
    logic append;      // store the vertex and report it as new
  } vdi_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hit;        // entry under compare matches the vertex
    logic exhausted;  // every stored entry compared, none matched
    logic full;       // no room left in the table
  } vdi_sts_t;

  function automatic logic is_nan(input logic [CoordW-1:0] b);
    is_nan = (b[CoordW-2:0] > 31'h7F80_0000);
  endfunction

  // IEEE equality: signed zeros match, NaN never matches
  function automatic logic float_eq(input logic [CoordW-1:0] a,
                                    input logic [CoordW-1:0] b);
    logic zeros;
    zeros = ((a[CoordW-2:0] | b[CoordW-2:0]) == '0);
    float_eq = !is_nan(a) && !is_nan(b) && (zeros || (a == b));
  endfunction

endpackage : vdi_pkg

`default_nettype wire

// File: rtl/core/vdi_ctrl.sv
// ----------------------------------------------------------------------------
// vdi_ctrl
// Sequencer: takes one vertex, steps the table search, commits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module vdi_ctrl
  import vdi_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire vdi_sts_t sts_i,
  output vdi_cmd_t      cmd_o
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   decide;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign decide     = (state_q == ST_SCAN) && (sts_i.hit || sts_i.exhausted) && slot_free;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // hold the search while a decision waits for the result slot
        cmd_o.scan = !(sts_i.hit || sts_i.exhausted);
        if (decide) begin
          if (sts_i.hit) begin
            cmd_o.load_match = 1'b1;
          end else if (sts_i.full) begin
            cmd_o.load_full = 1'b1;
          end else begin
            cmd_o.append = 1'b1;
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule : vdi_ctrl

`default_nettype wire

// File: rtl/core/vdi_datapath.sv
// ----------------------------------------------------------------------------
// vdi_datapath
// Unique-vertex table, search pointer, comparator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vdi_datapath
  import vdi_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = VdiTableDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire vdi_cmd_t          cmd_i,
  output vdi_sts_t               sts_o,
  input  wire logic              start_req_i,
  input  wire logic [CoordW-1:0] coord_x_i,
  input  wire logic [CoordW-1:0] coord_y_i,
  input  wire logic [CoordW-1:0] coord_z_i,
  output logic [IdxW-1:0]        vertex_index_o,
  output logic                   is_new_o,
  output logic                   table_full_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);

  logic [VertexW-1:0] mem [TABLE_DEPTH];

  logic [CoordW-1:0]  vx_q, vy_q, vz_q;
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    rd_ptr_q;
  logic               cmp_valid_q;
  logic [AddrW-1:0]   cmp_pos_q;
  logic [VertexW-1:0] rd_data_q;
  logic               rd_more;
  logic               entry_eq;

  logic [IdxW-1:0]    index_q;
  logic               is_new_q;
  logic               full_q;

  logic [CntW+IdxW-1:0]  count_ext;
  logic [AddrW+IdxW-1:0] pos_ext;

  assign count_ext = {{IdxW{1'b0}}, count_q};
  assign pos_ext   = {{IdxW{1'b0}}, cmp_pos_q};

  assign rd_more  = (rd_ptr_q != count_q);
  assign entry_eq = float_eq(vx_q, rd_data_q[VertexW-1 -: CoordW])
                 && float_eq(vy_q, rd_data_q[2*CoordW-1 -: CoordW])
                 && float_eq(vz_q, rd_data_q[CoordW-1:0]);

  assign sts_o.hit       = cmp_valid_q && entry_eq;
  assign sts_o.exhausted = !cmp_valid_q && !rd_more;
  assign sts_o.full      = (count_q == CntW'(TABLE_DEPTH));

  // table storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem[count_q[AddrW-1:0]] <= {vx_q, vy_q, vz_q};
    end
    if (cmd_i.scan && rd_more) begin
      rd_data_q <= mem[rd_ptr_q[AddrW-1:0]];
    end
  end

  // vertex and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vx_q <= coord_x_i;
      vy_q <= coord_y_i;
      vz_q <= coord_z_i;
    end
    if (cmd_i.scan && rd_more) begin
      cmp_pos_q <= rd_ptr_q[AddrW-1:0];
    end
    if (cmd_i.load_match) begin
      index_q  <= pos_ext[IdxW-1:0];
      is_new_q <= 1'b0;
      full_q   <= 1'b0;
    end else if (cmd_i.load_full) begin
      index_q  <= '0;
      is_new_q <= 1'b0;
      full_q   <= 1'b1;
    end else if (cmd_i.append) begin
      index_q  <= count_ext[IdxW-1:0];
      is_new_q <= 1'b1;
      full_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_ptr_q    <= '0;
      cmp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        // a start request drops the whole table before this vertex
        if (start_req_i) begin
          count_q <= '0;
        end
        rd_ptr_q    <= '0;
        cmp_valid_q <= 1'b0;
      end else if (cmd_i.scan) begin
        cmp_valid_q <= rd_more;
        if (rd_more) begin
          rd_ptr_q <= rd_ptr_q + 1'b1;
        end
      end else if (cmd_i.append) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  assign vertex_index_o = index_q;
  assign is_new_o       = is_new_q;
  assign table_full_o   = full_q;

endmodule : vdi_datapath

`default_nettype wire

// File: rtl/core/vertex_dedup_indexer_core.sv
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_core
// Vertex de-duplication index buffer: maps each vertex to its unique slot.
// ----------------------------------------------------------------------------
// Each input transfer carries one vertex (three IEEE single bit patterns) and
// a start flag that empties the table first. The core searches its stored
// unique vertices in insertion order, one entry per cycle through the single
// read port of the table memory, and returns the first match; otherwise it
// appends the vertex and flags it new, or flags table_full (index 0) when no
// slot is left. Coordinates compare as floats: +0 equals -0, NaN never
// matches. A vertex that matches entry p goes from accept to the next accept
// through one accept, p + 1 memory reads and one commit. A vertex with no
// match among n stored entries goes through one accept, n memory reads, one
// compare and one commit, or only the accept and the commit on an empty
// table. The search is the limit. The result sits in an output register, so
// a new vertex is taken while the previous result waits; the commit of that
// vertex then holds until the waiting result has been taken, which adds those
// stall cycles.
`default_nettype none

module vertex_dedup_indexer_core
  import vdi_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = VdiTableDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              start_req_i,
  input  wire logic [CoordW-1:0] coord_x_i,
  input  wire logic [CoordW-1:0] coord_y_i,
  input  wire logic [CoordW-1:0] coord_z_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [IdxW-1:0]        vertex_index_o,
  output logic                   is_new_o,
  output logic                   table_full_o
);

  vdi_cmd_t cmd;
  vdi_sts_t sts;

  vdi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vdi_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .start_req_i    (start_req_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .coord_z_i      (coord_z_i),
    .vertex_index_o (vertex_index_o),
    .is_new_o       (is_new_o),
    .table_full_o   (table_full_o)
  );

  // busy for the search after every accepted transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("accepted a vertex while a search was running");

  // a commit must come from a finished search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.append || cmd.load_full) |-> (sts.exhausted && !sts.hit))
    else $error("vertex committed before the search finished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.append |-> !sts.full)
    else $error("append into a full table");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_new_o && table_full_o))
    else $error("result flagged both new and table full");

endmodule : vertex_dedup_indexer_core

`default_nettype wire

// File: tb/vertex_dedup_indexer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_core_test
// Self-checking bench for the vertex de-duplication indexer core.
// ----------------------------------------------------------------------------
// A queue of vertices (directed corner cases, then random meshes with reused,
// sign-flipped and NaN coordinates, two of them filled past capacity) feeds a
// bursty driver. Each accepted vertex is indexed by a local slot table and the
// expected slot is queued; a stalling monitor checks every result against it.
// ----------------------------------------------------------------------------

module vertex_dedup_indexer_core_test;
  import vdi_pkg::*;

  localparam int unsigned Depth       = VdiTableDepth;
  localparam int unsigned TargetItems = 2000;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned TailCycles  = 300;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic    start;
    vertex_t v;
    logic    drain;
  } vertex_item_t;

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic            fresh;
    logic            full;
  } slot_result_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid    = 1'b0;
  logic              start_req   = 1'b0;
  logic [CoordW-1:0] coord_x     = '0;
  logic [CoordW-1:0] coord_y     = '0;
  logic [CoordW-1:0] coord_z     = '0;
  logic              out_ready   = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [IdxW-1:0]   vertex_index_o;
  logic              is_new_o;
  logic              table_full_o;

  // Local copy of the unique vertex table
  logic [CoordW-1:0] uniq_x [Depth];
  logic [CoordW-1:0] uniq_y [Depth];
  logic [CoordW-1:0] uniq_z [Depth];
  int unsigned       uniq_count = 0;

  vertex_item_t pending_q [$];
  slot_result_t slot_q [$];
  vertex_t      mesh_pool [$];

  int unsigned sent_cnt    = 0;
  int unsigned got_cnt     = 0;
  int unsigned errors      = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left    = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_left  = 0;
  int unsigned run_left    = 0;
  int unsigned n_items     = 0;
  bit          took;
  vertex_item_t cur;
  slot_result_t want;

  vertex_dedup_indexer_core #(
    .TABLE_DEPTH(Depth)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .start_req_i   (start_req),
    .coord_x_i     (coord_x),
    .coord_y_i     (coord_y),
    .coord_z_i     (coord_z),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .vertex_index_o(vertex_index_o),
    .is_new_o      (is_new_o),
    .table_full_o  (table_full_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic coord_same(input logic [CoordW-1:0] a,
                                      input logic [CoordW-1:0] b);
    if (a[CoordW-2:0] > 31'h7F80_0000 || b[CoordW-2:0] > 31'h7F80_0000) begin
      return 1'b0;
    end
    if ((a[CoordW-2:0] | b[CoordW-2:0]) == '0) begin
      return 1'b1;
    end
    return a == b;
  endfunction

  // Find or append the vertex and return the slot it lands in
  function automatic slot_result_t lookup_slot(input logic start, input vertex_t v);
    slot_result_t r;
    int           hit;
    int unsigned  p;
    hit = -1;
    if (start) begin
      uniq_count = 0;
    end
    for (p = 0; p < uniq_count && hit < 0; p++) begin
      if (coord_same(v.x, uniq_x[p]) && coord_same(v.y, uniq_y[p]) &&
          coord_same(v.z, uniq_z[p])) begin
        hit = p;
      end
    end
    if (hit >= 0) begin
      r = '{index: IdxW'(hit), fresh: 1'b0, full: 1'b0};
    end else if (uniq_count >= Depth) begin
      r = '{index: '0, fresh: 1'b0, full: 1'b1};
    end else begin
      uniq_x[uniq_count] = v.x;
      uniq_y[uniq_count] = v.y;
      uniq_z[uniq_count] = v.z;
      r = '{index: IdxW'(uniq_count), fresh: 1'b1, full: 1'b0};
      uniq_count++;
    end
    return r;
  endfunction

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return {1'($urandom), 31'd0};
      1:       return {1'($urandom), 8'hFF, 23'd0};
      2:       return {1'($urandom), 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
      3:       return {1'b0, 8'h7F, 20'd0, 3'($urandom)};
      default: return $urandom();
    endcase
  endfunction

  task automatic put(input logic s, input logic [CoordW-1:0] x, y, z,
                     input logic drain = 1'b0);
    vertex_item_t it;
    it = '{start: s, v: '{x: x, y: y, z: z}, drain: drain};
    pending_q.insert(pending_q.size(), it);
  endtask

  // Pick a vertex already seen in this mesh, giving any zero a random sign
  function automatic vertex_t reuse_vertex();
    vertex_t v;
    v = mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
    if (v.x[CoordW-2:0] == '0) v.x[CoordW-1] = 1'($urandom);
    if (v.y[CoordW-2:0] == '0) v.y[CoordW-1] = 1'($urandom);
    if (v.z[CoordW-2:0] == '0) v.z[CoordW-1] = 1'($urandom);
    return v;
  endfunction

  task automatic random_mesh();
    vertex_t     v;
    int unsigned len;
    int unsigned k;
    logic        first_start;
    len = $urandom_range(1, 40);
    first_start = ($urandom_range(0, 9) != 0);
    if (first_start) mesh_pool.delete();
    for (k = 0; k < len; k++) begin
      if (mesh_pool.size() > 0 && $urandom_range(0, 1)) begin
        v = reuse_vertex();
      end else begin
        v = '{x: rand_coord(), y: rand_coord(), z: rand_coord()};
        mesh_pool.insert(mesh_pool.size(), v);
      end
      put(k == 0 && first_start, v.x, v.y, v.z, $urandom_range(0, 99) == 0);
    end
    n_items += len;
  endtask

  // Fill the table to capacity, then hit it with matches and overflows
  task automatic full_mesh();
    vertex_t     v;
    int unsigned k;
    mesh_pool.delete();
    for (k = 0; k < Depth; k++) begin
      v = '{x: {1'($urandom), 8'h3F, 15'($urandom), 8'(k)}, y: $urandom(), z: $urandom()};
      mesh_pool.insert(mesh_pool.size(), v);
      put(k == 0, v.x, v.y, v.z);
    end
    for (k = 0; k < 40; k++) begin
      if ($urandom_range(0, 1)) begin
        v = reuse_vertex();
      end else begin
        v = '{x: rand_coord(), y: rand_coord(), z: rand_coord()};
      end
      put(1'b0, v.x, v.y, v.z);
    end
    n_items += Depth + 40;
  endtask

  initial begin
    // Corner cases, starting from the table emptied by reset
    put(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    put(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    put(1'b0, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
    put(1'b0, 32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000);
    put(1'b0, 32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000);
    put(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put(1'b0, 32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF);
    put(1'b0, 32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF);
    put(1'b0, 32'h7F80_0001, 32'h0000_0000, 32'h0000_0000);
    put(1'b0, 32'h0000_0001, 32'h8000_0001, 32'h7F7F_FFFF);
    put(1'b0, 32'h0000_0001, 32'h0000_0001, 32'h7F7F_FFFF);
    put(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    put(1'b0, 32'h0000_0001, 32'h8000_0001, 32'h7F7F_FFFF);
    put(1'b0, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001);
    put(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    put(1'b0, 32'h3F80_0000, 32'h4000_0000, 32'hC040_0000);
    put(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
    put(1'b1, 32'h3F80_0000, 32'h4000_0000, 32'hC040_0000);
    put(1'b0, 32'h3F80_0000, 32'h4000_0000, 32'hC040_0000);
    put(1'b1, 32'hFF80_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    put(1'b0, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h8000_0000);
    put(1'b0, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h0000_0000);

    while (n_items < TargetItems) begin
      if (n_items >= 500 && n_items < 540) full_mesh();
      else if (n_items >= 1300 && n_items < 1340) full_mesh();
      else random_mesh();
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid || sent_cnt != got_cnt) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("vertex_dedup_indexer_core: match");
    end else begin
      $display("vertex_dedup_indexer_core: mismatch");
    end
    $finish;
  end

  // Driver: bursts with gaps, holding each vertex until its transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      took = in_valid && in_ready_o;
      if (took) begin
        slot_q.insert(slot_q.size(),
                      lookup_slot(start_req, '{x: coord_x, y: coord_y, z: coord_z}));
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() == 0 ||
                     (pending_q[0].drain && sent_cnt + int'(took) != got_cnt)) begin
          in_valid <= 1'b0;
        end else begin
          cur = pending_q.pop_front();
          in_valid  <= 1'b1;
          start_req <= cur.start;
          coord_x   <= cur.v.x;
          coord_y   <= cur.v.y;
          coord_z   <= cur.v.z;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
            gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 30);
          end
        end
      end
    end
  end

  // Monitor: check each result transfer, stall in runs of its own
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      got_cnt <= got_cnt + 1;
      if (slot_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result index %0d new %0b full %0b", $time,
                 vertex_index_o, is_new_o, table_full_o);
      end else begin
        want = slot_q.pop_front();
        if (vertex_index_o !== want.index) begin
          errors++;
          $display("%0t: vertex_index expected %0d actual %0d", $time, want.index,
                   vertex_index_o);
        end
        if (is_new_o !== want.fresh) begin
          errors++;
          $display("%0t: is_new expected %0b actual %0b", $time, want.fresh, is_new_o);
        end
        if (table_full_o !== want.full) begin
          errors++;
          $display("%0t: table_full expected %0b actual %0b", $time, want.full,
                   table_full_o);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (run_left > 0) begin
        run_left--;
      end else begin
        run_left   = $urandom_range(1, 60);
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end
    end
  end

  // Watchdog: give up when neither channel has moved for too long
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("vertex_dedup_indexer_core: mismatch");
      $finish;
    end
  end

endmodule
